// File: sv/ttu_pkg.sv
// ----------------------------------------------------------------------------
// ttu_pkg: shared types and constants of the text to UTF-32 transcoder
// Encoding mode codes, the request record passed from decoder to output
// stage, and the fixed code point constants.
// ----------------------------------------------------------------------------
`default_nettype none

package ttu_pkg;

    typedef enum logic [2:0] {
        ENC_UTF8     = 3'd0,
        ENC_UTF16_LE = 3'd1,
        ENC_UTF16_BE = 3'd2,
        ENC_UTF32_LE = 3'd3,
        ENC_UTF32_BE = 3'd4
    } t_enc_mode;

    // One decoded request: either a code point or an end-of-text marker.
    typedef struct packed {
        logic        is_end;
        logic [31:0] value;
    } t_cp_req;

    localparam logic [31:0] BOM_CODE  = 32'h0000_FEFF;
    localparam logic [31:0] SUPP_BASE = 32'h0001_0000;

endpackage

`default_nettype wire

// File: sv/ttu_front.sv
// ----------------------------------------------------------------------------
// ttu_front: byte-level decoder
// Holds the encoding mode and all sequence state, takes one byte per cycle
// on i_fire and produces a code point or end-of-text request for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ttu_front
    import ttu_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [2:0]  i_cfg_wr_data,
    input  wire logic        i_fire,
    input  wire logic [7:0]  i_byte,
    output logic             o_push,
    output t_cp_req          o_req
);

    t_enc_mode    r_mode;
    logic [1:0]   r_ubc,      n_ubc;
    logic [31:0]  r_ua,       n_ua;
    logic [1:0]   r_cont,     n_cont;
    logic [20:0]  r_acc,      n_acc;
    logic         r_pend,     n_pend;
    logic [9:0]   r_hb,       n_hb;

    logic         emit;
    logic         emit_end;
    logic [31:0]  emit_value;
    logic         lane16;
    logic [31:0]  asm16;
    logic [15:0]  unit16;
    logic [1:0]   lane32;
    logic [31:0]  asm32;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ENC_UTF8;
            r_ubc  <= '0;
            r_ua   <= '0;
            r_cont <= '0;
            r_acc  <= '0;
            r_pend <= 1'b0;
            r_hb   <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_mode <= t_enc_mode'(i_cfg_wr_data);
            end
            r_ubc  <= n_ubc;
            r_ua   <= n_ua;
            r_cont <= n_cont;
            r_acc  <= n_acc;
            r_pend <= n_pend;
            r_hb   <= n_hb;
        end
    end

    always_comb begin
        lane16 = (r_mode == ENC_UTF16_BE) ? ~r_ubc[0] : r_ubc[0];
        asm16  = r_ua | (lane16 ? {16'b0, i_byte, 8'b0} : {24'b0, i_byte});
        unit16 = asm16[15:0];
        lane32 = (r_mode == ENC_UTF32_BE) ? ~r_ubc : r_ubc;
        asm32  = r_ua | ({24'b0, i_byte} << {lane32, 3'b000});
    end

    always_comb begin
        n_ubc      = r_ubc;
        n_ua       = r_ua;
        n_cont     = r_cont;
        n_acc      = r_acc;
        n_pend     = r_pend;
        n_hb       = r_hb;
        emit       = 1'b0;
        emit_end   = 1'b0;
        emit_value = '0;
        if (i_fire) begin
            case (r_mode)
                ENC_UTF8: begin
                    if (r_cont != 2'd0) begin
                        case (r_cont)
                            2'd1:    n_acc = r_acc | {13'b0, i_byte ^ 8'h80};
                            2'd2:    n_acc = r_acc | {7'b0, i_byte ^ 8'h80, 6'b0};
                            default: n_acc = r_acc | {1'b0, i_byte ^ 8'h80, 12'b0};
                        endcase
                        n_cont = r_cont - 2'd1;
                        if (r_cont == 2'd1) begin
                            emit       = 1'b1;
                            emit_value = {11'b0, n_acc};
                            n_acc      = '0;
                        end
                    end else if (i_byte == 8'h00) begin
                        emit_end = 1'b1;
                    end else if (!i_byte[7]) begin
                        emit       = 1'b1;
                        emit_value = {24'b0, i_byte};
                    end else if (i_byte[7:5] == 3'b110) begin
                        n_acc  = {10'b0, i_byte[4:0], 6'b0};
                        n_cont = 2'd1;
                    end else if (i_byte[7:4] == 4'b1110) begin
                        n_acc  = {5'b0, i_byte[3:0], 12'b0};
                        n_cont = 2'd2;
                    end else if (i_byte[7:3] == 5'b11110) begin
                        n_acc  = {i_byte[2:0], 18'b0};
                        n_cont = 2'd3;
                    end else begin
                        // Invalid lead byte decodes as code point zero.
                        emit = 1'b1;
                    end
                end
                ENC_UTF16_LE, ENC_UTF16_BE: begin
                    if (!r_ubc[0]) begin
                        n_ua  = asm16;
                        n_ubc = 2'd1;
                    end else begin
                        n_ua  = '0;
                        n_ubc = 2'd0;
                        if (r_pend) begin
                            emit       = 1'b1;
                            emit_value = {12'b0, r_hb, unit16[9:0]} + SUPP_BASE;
                            n_pend     = 1'b0;
                            n_hb       = '0;
                        end else if (unit16 == 16'h0000) begin
                            emit_end = 1'b1;
                        end else if (unit16[15:11] == 5'b11011) begin
                            n_pend = 1'b1;
                            n_hb   = unit16[9:0];
                        end else begin
                            emit       = 1'b1;
                            emit_value = {16'b0, unit16};
                        end
                    end
                end
                ENC_UTF32_LE, ENC_UTF32_BE: begin
                    if (r_ubc != 2'd3) begin
                        n_ua  = asm32;
                        n_ubc = r_ubc + 2'd1;
                    end else begin
                        n_ua  = '0;
                        n_ubc = 2'd0;
                        if (asm32 == 32'h0) begin
                            emit_end = 1'b1;
                        end else begin
                            emit       = 1'b1;
                            emit_value = asm32;
                        end
                    end
                end
                default: begin
                end
            endcase
            if (emit_end) begin
                n_ubc  = '0;
                n_ua   = '0;
                n_cont = '0;
                n_acc  = '0;
                n_pend = 1'b0;
                n_hb   = '0;
            end
        end
    end

    assign o_push       = emit | emit_end;
    assign o_req.is_end = emit_end;
    assign o_req.value  = emit_value;

    a_end_clears_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_req.is_end) |=> (r_cont == 2'd0 && r_ubc == 2'd0 && !r_pend))
        else $error("decoder state not cleared after end of text");

    a_end_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_req.is_end) |-> (o_req.value == 32'h0))
        else $error("end-of-text request carries a nonzero value");

endmodule

`default_nettype wire

// File: sv/ttu_queue.sv
// ----------------------------------------------------------------------------
// ttu_queue: two-entry request queue
// Decouples the decoder from the output stage so each can stall alone.
// ----------------------------------------------------------------------------
`default_nettype none

module ttu_queue
    import ttu_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_cp_req i_req,
    input  wire logic    i_pop,
    output t_cp_req      o_head,
    output logic         o_empty,
    output logic         o_full
);

    t_cp_req     r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic        do_push;
    logic        do_pop;

    assign o_empty = (r_count == 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("request pushed into a full queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue count out of range");

endmodule

`default_nettype wire

// File: sv/ttu_back.sv
// ----------------------------------------------------------------------------
// ttu_back: output stage
// Drops a byte order mark at the start of each text and holds the result
// in an output register until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ttu_back
    import ttu_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_cp_req      i_head,
    input  wire logic         i_empty,
    output logic              o_pop,
    output logic              o_valid,
    input  wire logic         i_ready,
    output logic [31:0]       o_code_point,
    output logic              o_end_of_text
);

    logic         r_valid, n_valid;
    logic         r_first, n_first;
    logic [31:0]  r_data;
    logic         r_last;
    logic         take;
    logic         drop;

    assign take  = !r_valid || i_ready;
    assign o_pop = take && !i_empty;
    assign drop  = !i_head.is_end && r_first && (i_head.value == BOM_CODE);

    always_comb begin
        n_valid = r_valid;
        n_first = r_first;
        if (take) begin
            n_valid = o_pop && !drop;
        end
        if (o_pop) begin
            n_first = i_head.is_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_first <= 1'b1;
        end else begin
            r_valid <= n_valid;
            r_first <= n_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && !drop) begin
            r_data <= i_head.value;
            r_last <= i_head.is_end;
        end
    end

    assign o_valid       = r_valid;
    assign o_code_point  = r_data;
    assign o_end_of_text = r_last;

    a_end_rearms_bom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_head.is_end) |=> r_first)
        else $error("start-of-text flag not set after end of text");

    a_bom_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && drop) |=> !r_valid)
        else $error("leading byte order mark reached the output");

endmodule

`default_nettype wire

// File: sv/text_to_utf32_transcoder_unit.sv
// ----------------------------------------------------------------------------
// text_to_utf32_transcoder_unit: text to UTF-32 transcoder
// Decodes a byte stream in UTF-8, UTF-16 LE/BE or UTF-32 LE/BE into 32-bit
// code points, with end-of-text marking and leading byte order mark removal.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload                         Handshake
//  s_axis    in         tdata[7:0] = data_byte          tvalid / tready
//  m_axis    out        tdata[31:0] = code_point,       tvalid / tready
//                       tlast = end_of_text
//  cfg       in         wr_data[2:0] = encoding_mode    wr_en, no wait
//
// One byte is accepted per cycle while the queue has room. A finished
// request enters the queue at the edge that takes its last byte and moves
// to the output register once it is free. The decoder and output stage
// are split by a two-entry queue; input tready drops only when it is full.
// Reset is synchronous, active low, and returns the mode to UTF-8 and all
// decode state to the start of a text.
// ----------------------------------------------------------------------------
`default_nettype none

module text_to_utf32_transcoder_unit
    import ttu_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration: encoding_mode
    input  wire logic        i_cfg_wr_en,
    input  wire logic [2:0]  i_cfg_wr_data,
    // Input stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    // Output stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [31:0]      o_m_axis_tdata,   // [31:0] code_point
    output logic             o_m_axis_tlast    // end_of_text
);

    logic     fire;
    logic     push;
    t_cp_req  req;
    t_cp_req  head;
    logic     q_empty;
    logic     q_full;
    logic     pop;

    // Accept a byte whenever the queue can take whatever it may produce.
    assign o_s_axis_tready = !q_full;
    assign fire            = i_s_axis_tvalid && o_s_axis_tready;

    ttu_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_fire        (fire),
        .i_byte        (i_s_axis_tdata),
        .o_push        (push),
        .o_req         (req)
    );

    ttu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (req),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    ttu_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .i_empty       (q_empty),
        .o_pop         (pop),
        .o_valid       (o_m_axis_tvalid),
        .i_ready       (i_m_axis_tready),
        .o_code_point  (o_m_axis_tdata),
        .o_end_of_text (o_m_axis_tlast)
    );

endmodule

`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stream testbench for the text to UTF-32 transcoder
// Feeds encoded text byte by byte in every encoding mode and checks each
// decoded code point and end marker against a cycle-free decoder model that
// runs alongside. Mode changes fall between phases, mid-text state included.
// ----------------------------------------------------------------------------

module tb_top;
    import ttu_pkg::*;

    // Mode codes with no encoding behind them: the block takes the byte and
    // does nothing else.
    localparam logic [2:0] ENC_RESERVED_A = 3'd5;
    localparam logic [2:0] ENC_RESERVED_B = 3'd6;
    localparam logic [2:0] ENC_RESERVED_C = 3'd7;

    localparam int RANDOM_ITEMS      = 1400;
    // A finished request passes through the queue and then the output register
    // once its last byte is taken, so PIPE_FLUSH_CYCLES more let any stray result show up.
    localparam int PIPE_FLUSH_CYCLES = 8;
    // Cycles without any request moving on either stream before giving up.
    localparam int WATCHDOG_LIMIT    = 2000;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_wr_en     = 1'b0;
    logic [2:0]  i_cfg_wr_data   = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic [7:0]  i_s_axis_tdata  = '0;   // [7:0] data_byte
    logic        i_m_axis_tready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [31:0] o_m_axis_tdata;         // [31:0] code_point
    logic        o_m_axis_tlast;         // end_of_text

    text_to_utf32_transcoder_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Text bytes waiting to be sent, and the decoded requests still owed by
    // the block, oldest first.
    logic [7:0] pending_bytes[$];
    t_cp_req    expected_points[$];

    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned send_idle_pct  = 35;
    int unsigned recv_idle_pct  = 55;
    // Bytes taken by the block, counted by the monitor, and bytes the driver
    // has already dropped from the pending queue.
    int unsigned bytes_taken    = 0;
    int unsigned bytes_retired  = 0;

    task automatic queue_byte(input logic [7:0] b);
        pending_bytes.insert(pending_bytes.size(), b);
    endtask

    task automatic owe_result(input t_cp_req r);
        expected_points.insert(expected_points.size(), r);
    endtask

    // ------------------------------------------------------------------
    // Decoder model. The mode register survives the end of a text; all the
    // rest goes back to the start-of-text values there. A mode change keeps
    // whatever half-built unit or sequence is in flight.
    // ------------------------------------------------------------------
    logic [2:0]  enc_mode   = ENC_UTF8;
    logic [1:0]  unit_bytes = '0;    // bytes of the current 16/32-bit unit
    logic [31:0] unit_acc   = '0;    // that unit as built so far
    logic [1:0]  cont_left  = '0;    // UTF-8 continuation bytes still due
    logic [20:0] utf8_acc   = '0;    // UTF-8 value as built so far
    logic        surr_wait  = 1'b0;  // a surrogate waits for its partner
    logic [9:0]  surr_bits  = '0;    // low ten bits of that surrogate
    logic        text_start = 1'b1;  // nothing emitted yet in this text

    // A byte order mark is dropped only as the very first code point.
    task automatic emit_point(input logic [31:0] cp);
        logic first;
        first      = text_start;
        text_start = 1'b0;
        if (!(first && cp == BOM_CODE))
            owe_result('{is_end: 1'b0, value: cp});
    endtask

    task automatic emit_end_marker();
        unit_bytes = '0;
        unit_acc   = '0;
        cont_left  = '0;
        utf8_acc   = '0;
        surr_wait  = 1'b0;
        surr_bits  = '0;
        text_start = 1'b1;
        owe_result('{is_end: 1'b1, value: '0});
    endtask

    task automatic decode_utf8(input logic [7:0] b);
        int unsigned sh;
        logic [20:0] cp;
        if (cont_left != 0) begin
            // Any byte counts as a continuation here, zero and junk included.
            sh       = 6 * (int'(cont_left) - 1);
            utf8_acc = utf8_acc | 21'({24'd0, b ^ 8'h80} << sh);
            cont_left--;
            if (cont_left == 0) begin
                cp       = utf8_acc;
                utf8_acc = '0;
                emit_point({11'd0, cp});
            end
        end else if (b == 8'h00) begin
            emit_end_marker();
        end else if (b <= 8'h7F) begin
            emit_point({24'd0, b});
        end else if (b >= 8'hC0 && b <= 8'hDF) begin
            utf8_acc  = 21'({24'd0, b ^ 8'hC0} << 6);
            cont_left = 2'd1;
        end else if (b >= 8'hE0 && b <= 8'hEF) begin
            utf8_acc  = 21'({24'd0, b ^ 8'hE0} << 12);
            cont_left = 2'd2;
        end else if (b >= 8'hF0 && b <= 8'hF7) begin
            utf8_acc  = 21'({24'd0, b ^ 8'hF0} << 18);
            cont_left = 2'd3;
        end else begin
            // Stray continuation byte or a lead byte beyond F7.
            emit_point('0);
        end
    endtask

    task automatic decode_utf16(input logic [7:0] b, input logic big);
        logic        pos;
        int unsigned sh;
        logic [15:0] unit;
        // Only the low bit of the byte count matters, even when a 32-bit
        // unit was left half built by an earlier mode.
        pos      = unit_bytes[0];
        sh       = big ? 8 * (1 - int'(pos)) : 8 * int'(pos);
        unit_acc = unit_acc | ({24'd0, b} << sh);
        if (!pos) begin
            unit_bytes = 2'd1;
        end else begin
            unit       = unit_acc[15:0];
            unit_bytes = '0;
            unit_acc   = '0;
            if (surr_wait) begin
                // The partner gives only its low ten bits, and a zero partner
                // is plain data rather than an end of text.
                surr_wait = 1'b0;
                emit_point({12'd0, surr_bits, unit[9:0]} + SUPP_BASE);
                surr_bits = '0;
            end else if (unit == 16'h0000) begin
                emit_end_marker();
            end else if (unit >= 16'hD800 && unit <= 16'hDFFF) begin
                // Low surrogates open a pair as well.
                surr_wait = 1'b1;
                surr_bits = unit[9:0];
            end else begin
                emit_point({16'd0, unit});
            end
        end
    endtask

    task automatic decode_utf32(input logic [7:0] b, input logic big);
        int unsigned pos;
        int unsigned sh;
        logic [31:0] unit;
        pos      = unit_bytes;
        sh       = big ? 8 * (3 - pos) : 8 * pos;
        unit_acc = unit_acc | ({24'd0, b} << sh);
        if (pos != 3) begin
            unit_bytes = 2'(pos + 1);
        end else begin
            unit       = unit_acc;
            unit_bytes = '0;
            unit_acc   = '0;
            if (unit == 32'd0)
                emit_end_marker();
            else
                emit_point(unit);   // values past 10FFFF pass untouched
        end
    endtask

    task automatic transcode_byte(input logic [7:0] b);
        case (enc_mode)
            ENC_UTF8:     decode_utf8(b);
            ENC_UTF16_LE: decode_utf16(b, 1'b0);
            ENC_UTF16_BE: decode_utf16(b, 1'b1);
            ENC_UTF32_LE: decode_utf32(b, 1'b0);
            ENC_UTF32_BE: decode_utf32(b, 1'b1);
            default:      ;       // reserved modes swallow the byte
        endcase
    endtask

    // ------------------------------------------------------------------
    // Driver. Everything changes on the falling edge. A presented byte is
    // held until the block takes it; the next one may follow at once.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : driver
        logic taken;
        taken = (bytes_taken != bytes_retired);
        if (taken) begin
            pending_bytes.delete(0);
            bytes_retired++;
        end
        if (i_s_axis_tvalid && !taken) begin
            // Still waiting for the block to take the current request.
        end else if (pending_bytes.size() != 0 &&
                     $urandom_range(0, 99) >= send_idle_pct) begin
            i_s_axis_tvalid <= 1'b1;
            i_s_axis_tdata  <= pending_bytes[0];
        end else begin
            i_s_axis_tvalid <= 1'b0;
        end
        i_m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // Monitor. Samples on the rising edge. Results are checked before a
    // byte taken at the same edge is decoded, so a result can never match
    // an expectation raised by a byte that it cannot belong to.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_cp_req want;
        logic    moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_wr_en)
                enc_mode = i_cfg_wr_data;
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                moved = 1'b1;
                if (expected_points.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h end %b",
                             $time, o_m_axis_tdata, o_m_axis_tlast);
                    mismatch_count++;
                end else begin
                    want = expected_points[0];
                    expected_points.delete(0);
                    if (o_m_axis_tdata !== want.value) begin
                        $display("%0t: code point mismatch, expected %h, actual %h",
                                 $time, want.value, o_m_axis_tdata);
                        mismatch_count++;
                    end
                    if (o_m_axis_tlast !== want.is_end) begin
                        $display("%0t: end of text mismatch, expected %b, actual %b",
                                 $time, want.is_end, o_m_axis_tlast);
                        mismatch_count++;
                    end
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                moved = 1'b1;
                transcode_byte(i_s_axis_tdata);
                bytes_taken++;
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end

    // A stream that stops moving for this long means the block is stuck.
    initial begin : watchdog
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(negedge i_clk);
        $display("tb_top: errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Text generators. Mostly well-formed sequences with random content,
    // plus byte order marks, terminators, broken sequences and noise.
    // ------------------------------------------------------------------
    task automatic push_unit16(input logic [15:0] u, input logic big);
        if (big) begin
            queue_byte(u[15:8]);
            queue_byte(u[7:0]);
        end else begin
            queue_byte(u[7:0]);
            queue_byte(u[15:8]);
        end
    endtask

    task automatic push_unit32(input logic [31:0] u, input logic big);
        for (int k = 0; k < 4; k++)
            queue_byte(big ? u[31 - 8 * k -: 8] : u[8 * k +: 8]);
    endtask

    task automatic add_utf8_symbol();
        int unsigned pick;
        logic [20:0] cp;
        pick = $urandom_range(0, 99);
        cp   = 21'($urandom);
        if (pick < 5) begin
            queue_byte(8'h00);
        end else if (pick < 9) begin
            queue_byte(8'hEF);
            queue_byte(8'hBB);
            queue_byte(8'hBF);
        end else if (pick < 30) begin
            queue_byte(8'($urandom_range(1, 8'h7F)));
        end else if (pick < 45) begin
            queue_byte({3'b110, cp[10:6]});
            queue_byte({2'b10, cp[5:0]});
        end else if (pick < 60) begin
            queue_byte({4'b1110, cp[15:12]});
            queue_byte({2'b10, cp[11:6]});
            queue_byte({2'b10, cp[5:0]});
        end else if (pick < 75) begin
            queue_byte({5'b11110, cp[20:18]});
            queue_byte({2'b10, cp[17:12]});
            queue_byte({2'b10, cp[11:6]});
            queue_byte({2'b10, cp[5:0]});
        end else if (pick < 85) begin
            // A lead byte followed by arbitrary bytes, zeros among them.
            queue_byte(8'($urandom_range(8'hC0, 8'hF7)));
            repeat ($urandom_range(0, 3)) begin
                queue_byte(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
            end
        end else begin
            queue_byte(8'($urandom));
        end
    endtask

    task automatic add_utf16_symbol(input logic big);
        int unsigned pick;
        logic [15:0] u;
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            push_unit16(16'h0000, big);
        end else if (pick < 9) begin
            push_unit16(BOM_CODE[15:0], big);
        end else if (pick < 45) begin
            u = 16'($urandom_range(1, 16'hFFFF));
            if (u >= 16'hD800 && u <= 16'hDFFF)
                u = u ^ 16'h8000;
            push_unit16(u, big);
        end else if (pick < 70) begin
            push_unit16(16'hD800 | 16'($urandom_range(0, 10'h3FF)), big);
            push_unit16(16'hDC00 | 16'($urandom_range(0, 10'h3FF)), big);
        end else if (pick < 80) begin
            // A lone low surrogate takes whatever unit comes next.
            push_unit16(16'hDC00 | 16'($urandom_range(0, 10'h3FF)), big);
            push_unit16(16'($urandom), big);
        end else if (pick < 85) begin
            push_unit16(16'($urandom_range(16'hD800, 16'hDFFF)), big);
            push_unit16(16'h0000, big);
        end else if (pick < 96) begin
            push_unit16(16'($urandom), big);
        end else begin
            queue_byte(8'($urandom));
        end
    endtask

    task automatic add_utf32_symbol(input logic big);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            push_unit32(32'd0, big);
        else if (pick < 9)
            push_unit32(BOM_CODE, big);
        else if (pick < 60)
            push_unit32(32'($urandom_range(1, 32'h10FFFF)), big);
        else if (pick < 96)
            push_unit32($urandom, big);
        else
            queue_byte(8'($urandom));
    endtask

    task automatic add_symbol(input logic [2:0] mode);
        case (mode)
            ENC_UTF8:     add_utf8_symbol();
            ENC_UTF16_LE: add_utf16_symbol(1'b0);
            ENC_UTF16_BE: add_utf16_symbol(1'b1);
            ENC_UTF32_LE: add_utf32_symbol(1'b0);
            ENC_UTF32_BE: add_utf32_symbol(1'b1);
            default:      queue_byte(8'($urandom));
        endcase
    endtask

    task automatic push_bytes(input logic [7:0] seq[]);
        foreach (seq[k])
            queue_byte(seq[k]);
    endtask

    // Mode writes happen only with both streams quiet.
    task automatic write_mode(input logic [2:0] mode);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= mode;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        while (pending_bytes.size() != 0 || i_s_axis_tvalid ||
               expected_points.size() != 0)
            @(negedge i_clk);
        repeat (PIPE_FLUSH_CYCLES) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Sequencer: directed text first, then random phases, each in one mode.
    // ------------------------------------------------------------------
    initial begin : sequencer
        int unsigned random_items;
        int unsigned phase_target;
        int unsigned queued_at_start;
        int unsigned phase_count;
        int unsigned pick;
        logic [2:0]  mode;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // UTF-8 straight from reset: a byte order mark to drop, ASCII, a
        // continuation that is zero, a four byte sequence, a stray continuation
        // byte, a bad lead and the terminator.
        push_bytes('{8'hEF, 8'hBB, 8'hBF, 8'h41, 8'hC3, 8'h00,
                     8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h80, 8'hFF, 8'h00});
        wait_idle();

        // UTF-16 BE: mark, a surrogate pair, then half a unit left behind.
        write_mode(ENC_UTF16_BE);
        push_bytes('{8'hFE, 8'hFF, 8'hD8, 8'h3D, 8'hDE, 8'h00, 8'h12});
        wait_idle();

        // UTF-32 BE finishes that unit and yields a value past 10FFFF.
        write_mode(ENC_UTF32_BE);
        push_bytes('{8'hFF, 8'hFF, 8'hFF});
        wait_idle();

        write_mode(ENC_RESERVED_C);
        push_bytes('{8'h5A, 8'hA5});
        wait_idle();

        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            // Sender busy and receiver lazy first, then the reverse, then a
            // stretch at full rate on both sides.
            phase_count = (random_items * 3) / RANDOM_ITEMS;
            send_idle_pct = (phase_count == 0) ? 35 : (phase_count == 1) ? 55 : 0;
            recv_idle_pct = (phase_count == 0) ? 55 : (phase_count == 1) ? 35 : 0;

            pick = $urandom_range(0, 10);
            case (pick)
                0, 1:    mode = ENC_UTF8;
                2, 3:    mode = ENC_UTF16_LE;
                4, 5:    mode = ENC_UTF16_BE;
                6, 7:    mode = ENC_UTF32_LE;
                8, 9:    mode = ENC_UTF32_BE;
                default: begin
                    case ($urandom_range(0, 2))
                        0:       mode = ENC_RESERVED_A;
                        1:       mode = ENC_RESERVED_B;
                        default: mode = ENC_RESERVED_C;
                    endcase
                end
            endcase
            write_mode(mode);

            if (mode > ENC_UTF32_BE) begin
                repeat ($urandom_range(2, 8)) add_symbol(mode);
            end else begin
                phase_target    = $urandom_range(40, 120);
                queued_at_start = pending_bytes.size();
                while (pending_bytes.size() - queued_at_start < phase_target)
                    add_symbol(mode);
                random_items += pending_bytes.size() - queued_at_start;
            end
            wait_idle();
        end

        if (mismatch_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

// File: sim.f
sv/ttu_pkg.sv
sv/ttu_front.sv
sv/ttu_queue.sv
sv/ttu_back.sv
sv/text_to_utf32_transcoder_unit.sv
dv/tb_top.sv
